FILE: design/slot_allocator_active_list_macros.svh
// ----------------------------------------------------------------------------
// slot allocator assertion macros
// shared property shorthands for the slot allocator checks
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_ACTIVE_LIST_MACROS_SVH
`define SLOT_ALLOCATOR_ACTIVE_LIST_MACROS_SVH

// same-cycle implication, checked outside reset
`define SAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/sar_pkg.sv
// ----------------------------------------------------------------------------
// sar_pkg
// types and constants shared by the slot allocator modules
// ----------------------------------------------------------------------------
package sar_pkg;

  localparam int POOL_SLOTS = 64;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int CFG_W      = 7;

  localparam logic [LINK_W-1:0] NONE_LINK    = LINK_W'(POOL_SLOTS);
  localparam logic [CFG_W-1:0]  ACTIVE_RESET = CFG_W'(64);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_FOLLOW  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NOT_USED = 2'd2,
    ST_BEYOND   = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [SLOT_W-1:0]   slot;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [LINK_W-1:0]   next_link;
    logic [LINK_W-1:0]   head_slot;
    logic [LINK_W-1:0]   in_use_count;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    clear;
    logic    alloc_commit;
    logic    rel_unlink;
    logic    rel_commit;
    logic    follow_done;
    logic    set_status;
    status_t status_code;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t opcode;
    logic    free_empty;
    logic    slot_beyond;
    logic    slot_idle;
  } dp_status_t;

endpackage

FILE: design/slot_allocator_active_list.sv
// from the accepting edge, clear and rejected commands pass through check only, allocate
// and follow add one more state, release adds unlink then relink (two link table passes)
// the next command is taken in the cycle the result is shown; a new command is not
// taken while the last one is still busy
// reset rebuilds the pool at 64 slots through per-entry valid bits
// results are strobed for one cycle on done; the receiver cannot stall
// ----------------------------------------------------------------------------
// slot_allocator_active_list
// slot pool with a free list and a doubly linked in-use list
// ----------------------------------------------------------------------------
`include "slot_allocator_active_list_macros.svh"

module slot_allocator_active_list import sar_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  item_t            item,
  output logic             done,
  output result_t          result,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  sar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  sar_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  `SAR_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while busy")
  `SAR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "transfer not taken")
  `SAR_ASSERT_NOW(a_head_count, done, (result.head_slot == NONE_LINK) == (result.in_use_count == '0), "head and count disagree")
  `SAR_ASSERT_NOW(a_grant_zero, done && (result.status != ST_OK), result.granted_slot == '0, "grant on failed command")

endmodule

FILE: design/sar_ram.sv
// ----------------------------------------------------------------------------
// sar_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sar_datapath.sv
// ----------------------------------------------------------------------------
// sar_datapath
// link tables, list heads, counters and result registers of the allocator
// ----------------------------------------------------------------------------
module sar_datapath import sar_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  item_t            item,
  input  dp_cmd_t          cmd,
  output dp_status_t       stat,
  output result_t          result,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  logic [CFG_W-1:0]      active_slots;
  logic [LINK_W-1:0]     applied;
  logic [LINK_W-1:0]     applied_next;
  logic [LINK_W-1:0]     free_head;
  logic [LINK_W-1:0]     used_head;
  logic [LINK_W-1:0]     used_count;
  logic [POOL_SLOTS-1:0] in_use;
  logic [POOL_SLOTS-1:0] next_vld;
  logic [POOL_SLOTS-1:0] prev_vld;

  opcode_t               op_r;
  logic [SLOT_W-1:0]     slot_r;
  status_t               status_r;
  logic [SLOT_W-1:0]     granted_r;
  logic [LINK_W-1:0]     link_r;

  logic [SLOT_W-1:0]     raddr;
  logic [SLOT_W-1:0]     rd_addr_q;
  logic                  next_vld_q;
  logic                  prev_vld_q;
  logic [LINK_W-1:0]     next_q;
  logic [LINK_W-1:0]     prev_q;
  logic [LINK_W-1:0]     succ;
  logic [LINK_W-1:0]     next_val;
  logic [LINK_W-1:0]     prev_val;

  logic                  next_we;
  logic [SLOT_W-1:0]     next_waddr;
  logic [LINK_W-1:0]     next_wdata;
  logic                  prev_we;
  logic [SLOT_W-1:0]     prev_waddr;
  logic [LINK_W-1:0]     prev_wdata;
  logic                  prev_inval;
  logic [SLOT_W-1:0]     prev_inval_addr;

  // clamp of the configured slot count
  always_comb begin
    if (active_slots == '0) begin
      applied_next = LINK_W'(1);
    end else if (int'(active_slots) > POOL_SLOTS) begin
      applied_next = NONE_LINK;
    end else begin
      applied_next = LINK_W'(active_slots);
    end
  end

  assign raddr = (op_r == OP_ALLOC) ? free_head[SLOT_W-1:0] : slot_r;

  // entries never written since clear read as the rebuilt chain
  assign succ     = {1'b0, rd_addr_q} + LINK_W'(1);
  assign next_val = next_vld_q ? next_q : ((succ < applied) ? succ : NONE_LINK);
  assign prev_val = prev_vld_q ? prev_q : NONE_LINK;

  always_comb begin
    next_we         = 1'b0;
    next_waddr      = slot_r;
    next_wdata      = free_head;
    prev_we         = 1'b0;
    prev_waddr      = used_head[SLOT_W-1:0];
    prev_wdata      = free_head;
    prev_inval      = 1'b0;
    prev_inval_addr = slot_r;
    if (cmd.alloc_commit) begin
      next_we         = 1'b1;
      next_waddr      = free_head[SLOT_W-1:0];
      next_wdata      = used_head;
      prev_we         = !used_head[SLOT_W];
      prev_waddr      = used_head[SLOT_W-1:0];
      prev_wdata      = free_head;
      prev_inval      = 1'b1;
      prev_inval_addr = free_head[SLOT_W-1:0];
    end else if (cmd.rel_unlink) begin
      next_we    = !prev_val[SLOT_W];
      next_waddr = prev_val[SLOT_W-1:0];
      next_wdata = next_val;
      prev_we    = !next_val[SLOT_W];
      prev_waddr = next_val[SLOT_W-1:0];
      prev_wdata = prev_val;
    end else if (cmd.rel_commit) begin
      next_we         = 1'b1;
      next_waddr      = slot_r;
      next_wdata      = free_head;
      prev_inval      = 1'b1;
      prev_inval_addr = slot_r;
    end
  end

  sar_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (raddr),
    .rdata (next_q)
  );

  sar_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (raddr),
    .rdata (prev_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= ACTIVE_RESET;
      applied      <= NONE_LINK;
      free_head    <= '0;
      used_head    <= NONE_LINK;
      used_count   <= '0;
      in_use       <= '0;
      next_vld     <= '0;
      prev_vld     <= '0;
    end else begin
      if (cfg_wr_en) begin
        active_slots <= cfg_wr_data;
      end
      if (cmd.clear) begin
        applied    <= applied_next;
        free_head  <= '0;
        used_head  <= NONE_LINK;
        used_count <= '0;
        in_use     <= '0;
        next_vld   <= '0;
        prev_vld   <= '0;
      end
      if (cmd.alloc_commit) begin
        free_head                      <= next_val;
        used_head                      <= free_head;
        in_use[free_head[SLOT_W-1:0]] <= 1'b1;
        used_count                     <= used_count + LINK_W'(1);
      end
      if (cmd.rel_unlink && (used_head == {1'b0, slot_r})) begin
        used_head <= next_val;
      end
      if (cmd.rel_commit) begin
        free_head      <= {1'b0, slot_r};
        in_use[slot_r] <= 1'b0;
        if (used_count != '0) begin
          used_count <= used_count - LINK_W'(1);
        end
      end
      if (next_we) begin
        next_vld[next_waddr] <= 1'b1;
      end
      if (prev_we) begin
        prev_vld[prev_waddr] <= 1'b1;
      end
      if (prev_inval) begin
        prev_vld[prev_inval_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q  <= raddr;
    next_vld_q <= next_vld[raddr];
    prev_vld_q <= prev_vld[raddr];
    if (cmd.capture) begin
      op_r      <= item.opcode;
      slot_r    <= item.slot;
      status_r  <= ST_OK;
      granted_r <= '0;
      link_r    <= NONE_LINK;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.alloc_commit) begin
      granted_r <= free_head[SLOT_W-1:0];
    end
    if (cmd.follow_done) begin
      link_r <= next_val;
    end
  end

  assign stat.opcode      = op_r;
  assign stat.free_empty  = free_head[SLOT_W];
  assign stat.slot_beyond = ({1'b0, slot_r} >= applied);
  assign stat.slot_idle   = !in_use[slot_r];

  assign result.status       = status_r;
  assign result.granted_slot = granted_r;
  assign result.next_link    = link_r;
  assign result.head_slot    = used_head;
  assign result.in_use_count = used_count;

endmodule

FILE: design/sar_ctrl.sv
// ----------------------------------------------------------------------------
// sar_ctrl
// sequencer for allocate, release, clear and follow commands
// ----------------------------------------------------------------------------
module sar_ctrl import sar_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  input  dp_status_t stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC,
    S_UNLINK,
    S_RELINK,
    S_FOLLOW
  } state_t;

  state_t state;
  logic   slot_bad;

  assign slot_bad = stat.slot_beyond || stat.slot_idle;

  always_comb begin
    cmd             = '0;
    cmd.status_code = ST_OK;
    unique case (state)
      S_IDLE:   cmd.capture = start;
      S_CHECK: begin
        unique case (stat.opcode)
          OP_ALLOC: begin
            cmd.set_status  = stat.free_empty;
            cmd.status_code = ST_NO_FREE;
          end
          OP_CLEAR: cmd.clear = 1'b1;
          OP_RELEASE, OP_FOLLOW: begin
            cmd.set_status  = slot_bad;
            cmd.status_code = stat.slot_beyond ? ST_BEYOND : ST_NOT_USED;
          end
          default: cmd.clear = 1'b0;
        endcase
      end
      S_ALLOC:  cmd.alloc_commit = 1'b1;
      S_UNLINK: cmd.rel_unlink   = 1'b1;
      S_RELINK: cmd.rel_commit   = 1'b1;
      S_FOLLOW: cmd.follow_done  = 1'b1;
      default:  cmd.capture      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CHECK;
            busy  <= 1'b1;
          end
        end
        S_CHECK: begin
          unique case (stat.opcode)
            OP_ALLOC: begin
              if (stat.free_empty) begin
                state <= S_IDLE;
                busy  <= 1'b0;
                done  <= 1'b1;
              end else begin
                state <= S_ALLOC;
              end
            end
            OP_CLEAR: begin
              state <= S_IDLE;
              busy  <= 1'b0;
              done  <= 1'b1;
            end
            OP_RELEASE, OP_FOLLOW: begin
              if (slot_bad) begin
                state <= S_IDLE;
                busy  <= 1'b0;
                done  <= 1'b1;
              end else if (stat.opcode == OP_FOLLOW) begin
                state <= S_FOLLOW;
              end else begin
                state <= S_UNLINK;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_UNLINK: state <= S_RELINK;
        S_ALLOC, S_RELINK, S_FOLLOW: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
